### rtl/htbd_pkg.sv
// ----------------------------------------------------------------------------
// htbd_pkg
// shared constants, node layout, request codes and the command and status
// bundles that pass between the controller and the datapath
// ----------------------------------------------------------------------------
`default_nettype none

package htbd_pkg;

   // tree sizing
   localparam int NODE_COUNT   = 512;
   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 32;

   // item field widths
   localparam int REQ_W = 2;
   localparam int PAT_W = 32;
   localparam int LEN_W = 6;
   localparam int SYM_W = 8;

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int USED_W  = $clog2(NODE_COUNT + 1);
   localparam int LEN_CAP = (MAX_CODE_LEN < PAT_W) ? MAX_CODE_LEN : PAT_W;

   // request codes
   localparam logic [REQ_W-1:0] REQ_DECODE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

   // result selection
   localparam logic [1:0] OUT_ZERO    = 2'd0;
   localparam logic [1:0] OUT_FULL    = 2'd1;
   localparam logic [1:0] OUT_DEC_IMM = 2'd2;
   localparam logic [1:0] OUT_DEC_HOP = 2'd3;

   typedef struct packed {
      logic [NODE_W-1:0] left;
      logic [NODE_W-1:0] right;
      logic [SYM_W-1:0]  sym;
   } node_type;

   typedef struct packed {
      logic       dec_imm;
      logic       dec_hop;
      logic       dec_fin;
      logic       clear;
      logic       ins_start;
      logic       ins_finish;
      logic       ins_descend;
      logic       ins_attach;
      logic       ins_stop;
      logic       ins_load;
      logic       out_load;
      logic [1:0] out_sel;
   } cmd_type;

   typedef struct packed {
      logic dec_hop_ok;
      logic ins_at_end;
      logic ins_slot_free;
      logic pool_empty;
   } status_type;

   // clamp a symbol into the symbol alphabet
   function automatic logic [SYM_W-1:0] sat_symbol(input logic [SYM_W-1:0] s);
      logic [SYM_W-1:0] r;
      if ({4'b0000, s} >= 12'(SYMBOL_COUNT)) begin
         r = SYM_W'(SYMBOL_COUNT - 1);
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/htbd_ctrl.sv
// ----------------------------------------------------------------------------
// htbd_ctrl
// sequencer for decode, insert and clear items plus the result valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module htbd_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [htbd_pkg::REQ_W-1:0]    req_type,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire htbd_pkg::status_type          status,
   output htbd_pkg::cmd_type                  cmd
);
   import htbd_pkg::*;

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_DEC_WAIT = 2'd1;
   localparam logic [1:0] ST_INS_STEP = 2'd2;
   localparam logic [1:0] ST_INS_LOAD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      out_free = !rsp_valid_ff || !rsp_stall;
      req_stall = reset || !((state_ff == ST_IDLE) && out_free);
      accept   = req_valid && !req_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_DECODE: begin
                     if (status.dec_hop_ok) begin
                        cmd.dec_hop = 1'b1;
                        state_in    = ST_DEC_WAIT;
                     end else begin
                        cmd.dec_imm  = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_DEC_IMM;
                     end
                  end
                  REQ_INSERT: begin
                     cmd.ins_start = 1'b1;
                     state_in      = ST_INS_STEP;
                  end
                  REQ_CLEAR: begin
                     cmd.clear    = 1'b1;
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_ZERO;
                  end
                  default: begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_ZERO;
                  end
               endcase
            end
         end
         ST_DEC_WAIT: begin
            cmd.dec_fin  = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_sel  = OUT_DEC_HOP;
            state_in     = ST_IDLE;
         end
         ST_INS_STEP: begin
            if (status.ins_at_end) begin
               cmd.ins_finish = 1'b1;
               cmd.out_load   = 1'b1;
               cmd.out_sel    = OUT_ZERO;
               state_in       = ST_IDLE;
            end else if (!status.ins_slot_free) begin
               cmd.ins_descend = 1'b1;
               state_in        = ST_INS_LOAD;
            end else if (!status.pool_empty) begin
               cmd.ins_attach = 1'b1;
            end else begin
               cmd.ins_stop = 1'b1;
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_FULL;
               state_in     = ST_IDLE;
            end
         end
         ST_INS_LOAD: begin
            cmd.ins_load = 1'b1;
            state_in     = ST_INS_STEP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/htbd_dpath.sv
// ----------------------------------------------------------------------------
// htbd_dpath
// node memory, root node, pool counter, decode walk, insert walk and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module htbd_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire htbd_pkg::cmd_type             cmd,
   output htbd_pkg::status_type               status,
   input  wire logic                          req_code_bit,
   input  wire logic [htbd_pkg::PAT_W-1:0]    req_code_pattern,
   input  wire logic [htbd_pkg::LEN_W-1:0]    req_code_length,
   input  wire logic [htbd_pkg::SYM_W-1:0]    req_code_symbol,
   output logic                               rsp_symbol_found,
   output logic [htbd_pkg::SYM_W-1:0]         rsp_symbol,
   output logic                               rsp_pool_full
);
   import htbd_pkg::*;

   // node memory, entry zero unused (root lives in flops)
   node_type node_mem_ff [NODE_COUNT];
   node_type rd_data_ff;

   node_type            root_ff, root_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [NODE_W-1:0]   walk_ff, walk_in;
   logic                rewind_ff, rewind_in;
   node_type            cache_ff, cache_in;
   logic [NODE_W-1:0]   hop_ff, hop_in;
   logic [NODE_W-1:0]   ins_pos_ff, ins_pos_in;
   node_type            ins_node_ff, ins_node_in;
   logic                ins_dirty_ff, ins_dirty_in;
   logic [PAT_W-1:0]    pat_ff, pat_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic                found_ff, found_in;
   logic [SYM_W-1:0]    osym_ff, osym_in;
   logic                full_ff, full_in;

   node_type            src;
   logic [NODE_W-1:0]   pos_eff;
   logic [NODE_W-1:0]   next_node;
   logic                src_leaf;
   logic                fin_leaf;
   logic [NODE_W-1:0]   slot;
   logic [LEN_W-1:0]    len_sat;

   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   node_type            wr_data;
   logic                wr_mem;
   logic                wr_root;
   logic                rd_en;
   logic [NODE_W-1:0]   rd_addr;

   always_comb begin
      // current decode node: root after a symbol or at node zero
      src       = (rewind_ff || (walk_ff == '0)) ? root_ff : cache_ff;
      pos_eff   = rewind_ff ? '0 : walk_ff;
      next_node = req_code_bit ? src.right : src.left;
      src_leaf  = (src.left == '0) && (src.right == '0);
      fin_leaf  = (rd_data_ff.left == '0) && (rd_data_ff.right == '0);
      slot      = pat_ff[0] ? ins_node_ff.right : ins_node_ff.left;
      len_sat   = (req_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req_code_length;

      status.dec_hop_ok    = (next_node != '0);
      status.ins_at_end    = (rem_ff == '0);
      status.ins_slot_free = (slot == '0);
      status.pool_empty    = (used_ff >= USED_W'(NODE_COUNT));
   end

   // single write port shared by insert write-backs
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ins_pos_ff;
      wr_data = ins_node_ff;
      if (cmd.ins_finish) begin
         wr_en       = 1'b1;
         wr_data.sym = sym_ff;
      end else if (cmd.ins_attach) begin
         wr_en = 1'b1;
         if (pat_ff[0]) begin
            wr_data.right = used_ff[NODE_W-1:0];
         end else begin
            wr_data.left = used_ff[NODE_W-1:0];
         end
      end else if (cmd.ins_descend || cmd.ins_stop) begin
         wr_en = ins_dirty_ff;
      end
      wr_mem  = wr_en && (wr_addr != '0);
      wr_root = wr_en && (wr_addr == '0);
      rd_en   = cmd.dec_hop || cmd.ins_descend;
      rd_addr = cmd.dec_hop ? next_node : slot;
   end

   always_comb begin
      root_in      = root_ff;
      used_in      = used_ff;
      walk_in      = walk_ff;
      rewind_in    = rewind_ff;
      cache_in     = cache_ff;
      hop_in       = hop_ff;
      ins_pos_in   = ins_pos_ff;
      ins_node_in  = ins_node_ff;
      ins_dirty_in = ins_dirty_ff;
      pat_in       = pat_ff;
      rem_in       = rem_ff;
      sym_in       = sym_ff;
      found_in     = found_ff;
      osym_in      = osym_ff;
      full_in      = full_ff;

      if (cmd.clear) begin
         root_in   = '0;
         used_in   = USED_W'(1);
         walk_in   = '0;
         rewind_in = 1'b1;
      end
      if (wr_root) begin
         root_in = wr_data;
      end
      // keep the cached walk node coherent with insert writes
      if (wr_mem && (wr_addr == walk_ff)) begin
         cache_in = wr_data;
      end

      if (cmd.dec_imm) begin
         walk_in   = pos_eff;
         rewind_in = src_leaf;
      end
      if (cmd.dec_hop) begin
         hop_in    = next_node;
         rewind_in = 1'b0;
      end
      if (cmd.dec_fin) begin
         walk_in   = hop_ff;
         cache_in  = rd_data_ff;
         rewind_in = fin_leaf;
      end

      if (cmd.ins_start) begin
         ins_pos_in   = '0;
         ins_node_in  = root_ff;
         ins_dirty_in = 1'b0;
         pat_in       = req_code_pattern;
         rem_in       = len_sat;
         sym_in       = sat_symbol(req_code_symbol);
      end
      if (cmd.ins_descend) begin
         ins_pos_in = slot;
         pat_in     = pat_ff >> 1;
         rem_in     = rem_ff - LEN_W'(1);
      end
      if (cmd.ins_attach) begin
         ins_pos_in   = used_ff[NODE_W-1:0];
         ins_node_in  = '0;
         ins_dirty_in = 1'b1;
         used_in      = used_ff + USED_W'(1);
         pat_in       = pat_ff >> 1;
         rem_in       = rem_ff - LEN_W'(1);
      end
      if (cmd.ins_load) begin
         ins_node_in  = rd_data_ff;
         ins_dirty_in = 1'b0;
      end

      if (cmd.out_load) begin
         found_in = 1'b0;
         osym_in  = '0;
         full_in  = 1'b0;
         case (cmd.out_sel)
            OUT_DEC_IMM: begin
               found_in = src_leaf;
               osym_in  = src_leaf ? src.sym : '0;
            end
            OUT_DEC_HOP: begin
               found_in = fin_leaf;
               osym_in  = fin_leaf ? rd_data_ff.sym : '0;
            end
            OUT_FULL: begin
               full_in = 1'b1;
            end
            default: begin
               full_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         used_ff      <= USED_W'(1);
         walk_ff      <= '0;
         rewind_ff    <= 1'b1;
         ins_dirty_ff <= 1'b0;
      end else begin
         root_ff      <= root_in;
         used_ff      <= used_in;
         walk_ff      <= walk_in;
         rewind_ff    <= rewind_in;
         ins_dirty_ff <= ins_dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      cache_ff    <= cache_in;
      hop_ff      <= hop_in;
      ins_pos_ff  <= ins_pos_in;
      ins_node_ff <= ins_node_in;
      pat_ff      <= pat_in;
      rem_ff      <= rem_in;
      sym_ff      <= sym_in;
      found_ff    <= found_in;
      osym_ff     <= osym_in;
      full_ff     <= full_in;
   end

   always_ff @(posedge clock) begin
      if (wr_mem) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem_ff[rd_addr];
      end
   end

   assign rsp_symbol_found = found_ff;
   assign rsp_symbol       = osym_ff;
   assign rsp_pool_full    = full_ff;

endmodule

`default_nettype wire

### rtl/huffman_tree_bit_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// bit-at-a-time huffman decoder over a binary code tree in a node memory
// ----------------------------------------------------------------------------
// Each request item is one of: decode one bit, insert a code, or clear the
// tree, and each produces exactly one result item. A decode bit that names
// no child, and a clear, load the result register as they are accepted. A
// decode bit that moves to a child first does a registered read of that
// child from the single-read-port node memory, then loads the result. An
// insert starts, does a node memory read plus a load for each node already
// present along the code and an attach for each node it adds, then finishes,
// or stops with pool full when no free node is left.
// The pool of free nodes is handed out in order and tracked by a fill count,
// so reset and clear take effect at once with no sweep of the memory; the
// root node sits in flops. One item is in flight at a time; a new item is
// taken once the result register is empty or is being drained that cycle.
`default_nettype none

module huffman_tree_bit_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request items
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [htbd_pkg::REQ_W-1:0]    req_type,
   input  wire logic                          req_code_bit,
   input  wire logic [htbd_pkg::PAT_W-1:0]    req_code_pattern,
   input  wire logic [htbd_pkg::LEN_W-1:0]    req_code_length,
   input  wire logic [htbd_pkg::SYM_W-1:0]    req_code_symbol,
   // result items
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_symbol_found,
   output logic [htbd_pkg::SYM_W-1:0]         rsp_symbol,
   output logic                               rsp_pool_full
);
   import htbd_pkg::*;

   // command and status bundles between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: handshake, item decoding, insert walk steps
   htbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: node memory, root, pool counter, walk state, result register
   htbd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_code_bit     (req_code_bit),
      .req_code_pattern (req_code_pattern),
      .req_code_length  (req_code_length),
      .req_code_symbol  (req_code_symbol),
      .rsp_symbol_found (rsp_symbol_found),
      .rsp_symbol       (rsp_symbol),
      .rsp_pool_full    (rsp_pool_full)
   );

endmodule

`default_nettype wire

### rtl/htbd_checker.sv
// ----------------------------------------------------------------------------
// htbd_checker
// port-level checks on the decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module htbd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [htbd_pkg::REQ_W-1:0]    req_type,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_symbol_found,
   input wire logic [htbd_pkg::SYM_W-1:0]    rsp_symbol,
   input wire logic                          rsp_pool_full
);
   import htbd_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol_found)
         && $stable(rsp_symbol) && $stable(rsp_pool_full))
      else $error("result changed while stalled");

   // no new item while a result is blocked
   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item accepted while result blocked");

   // found and pool full never together, symbol zero unless found
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_symbol_found && rsp_pool_full)
         && (rsp_symbol_found || (rsp_symbol == '0)))
      else $error("inconsistent result fields");

   // clear answers on the next cycle with an empty result
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_CLEAR)
         |=> rsp_valid && !rsp_symbol_found && !rsp_pool_full)
      else $error("clear result missing");

endmodule

bind huffman_tree_bit_decoder htbd_checker u_checker (.*);

`default_nettype wire
